// ===== sv/cfpd_pkg.sv =====
package cfpd_pkg;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_SHORT       = 3'd1,
        ST_BAD_START   = 3'd2,
        ST_BAD_VERSION = 3'd3,
        ST_BAD_LENGTH  = 3'd4,
        ST_BAD_CRC     = 3'd5
    } t_status;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_START_ONE = 2'd0,
        REG_START_TWO = 2'd1,
        REG_VERSION   = 2'd2,
        REG_UNUSED    = 2'd3
    } t_reg_index;

    localparam logic [7:0]  START_ONE_RST = 8'hAA;
    localparam logic [7:0]  START_TWO_RST = 8'h55;
    localparam logic [7:0]  VERSION_RST   = 8'h01;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // Byte offsets within a frame
    localparam logic [7:0]  OFS_START_ONE = 8'd0;
    localparam logic [7:0]  OFS_START_TWO = 8'd1;
    localparam logic [7:0]  OFS_VERSION   = 8'd2;
    localparam logic [7:0]  OFS_TYPE      = 8'd3;
    localparam logic [7:0]  OFS_SEQ       = 8'd4;
    localparam logic [7:0]  OFS_LENGTH    = 8'd5;
    localparam logic [7:0]  OFS_PAYLOAD   = 8'd6;

    localparam logic [7:0]  MIN_FRAME_LEN  = 8'd8;
    localparam logic [8:0]  FRAME_OVERHEAD = 9'd8;
    localparam logic [7:0]  COUNT_MAX      = 8'hFF;

endpackage

// ===== sv/crc_framed_packet_decoder_core.sv =====
// The status/header result is registered into the output register as the last byte of a
// frame is accepted; payload results follow one per cycle when not stalled.
// Input: one frame byte per cycle, unless stalled: a last byte waits for a free output slot,
// and after a good frame the input stalls while its payload burst leaves (one store read port).
// Reset (synchronous, active low) restores the start, version and frame state; the payload
// store is not cleared, as only entries written during the current frame are ever read.
module crc_framed_packet_decoder_core
    import cfpd_pkg::*;
#(
    parameter int MAX_PAYLOAD = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // Frame byte input
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,

    // Result output
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [7:0]  o_msg_type,
    output logic [7:0]  o_seq_num,
    output logic [5:0]  o_pay_len,
    output logic [7:0]  o_payload_byte,
    output logic        o_byte_valid,
    output logic        o_last_result,

    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Store index width and burst counter width follow from the payload limit
    localparam int         IDX_W   = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int         LEFT_W  = $clog2(MAX_PAYLOAD + 1);
    localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [7:0] r_start_one;
    logic [7:0] r_start_two;
    logic [7:0] r_version;
    logic       cfg_write;
    t_reg_index cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = t_reg_index'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_one <= START_ONE_RST;
            r_start_two <= START_TWO_RST;
            r_version   <= VERSION_RST;
        end else if (cfg_write) begin
            case (cfg_index)
                REG_START_ONE: r_start_one <= pwdata[7:0];
                REG_START_TWO: r_start_two <= pwdata[7:0];
                REG_VERSION:   r_version   <= pwdata[7:0];
                default: ; // drop writes outside the register map
            endcase
        end
    end

    always_comb begin
        case (cfg_index)
            REG_START_ONE: prdata = {24'd0, r_start_one};
            REG_START_TWO: prdata = {24'd0, r_start_two};
            REG_VERSION:   prdata = {24'd0, r_version};
            default:       prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Per-frame state
    // ------------------------------------------------------------------
    logic [7:0]  r_byte_count;
    logic [15:0] r_crc;
    logic        r_start_ok;
    logic        r_version_ok;
    logic [7:0]  r_length;
    logic [7:0]  r_type;
    logic [7:0]  r_seq;
    logic [7:0]  r_hold0;
    logic [7:0]  r_hold1;
    logic [7:0]  r_store [MAX_PAYLOAD];

    logic [7:0]  n_byte_count;
    logic [15:0] n_crc;
    logic        n_start_ok;
    logic        n_version_ok;
    logic [7:0]  n_length;
    logic [7:0]  n_type;
    logic [7:0]  n_seq;
    logic [15:0] crc_fed;
    logic [7:0]  store_ofs;
    logic        store_we;

    // Output side
    logic             r_out_valid;
    t_status          r_status;
    logic [7:0]       r_out_type;
    logic [7:0]       r_out_seq;
    logic [5:0]       r_out_len;
    logic [7:0]       r_out_byte;
    logic             r_out_bvalid;
    logic             r_out_last;

    // Payload burst control
    logic             r_burst;
    logic [IDX_W-1:0] r_rd_idx;
    logic [LEFT_W-1:0] r_left;

    logic    in_accept;
    logic    out_free;
    logic    load_hdr;
    logic    load_burst;
    t_status n_status;
    logic    frame_ok;

    // Bytes keep flowing while a result waits, except during a payload burst; only a last byte needs a free output slot
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_burst || (i_last_byte && !out_free);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign load_hdr   = in_accept && i_last_byte;
    assign load_burst = r_burst && out_free;

    // The CRC takes each byte two bytes late, so the trailing pair never enters it
    cfpd_crc_byte u_crc (
        .i_crc  (r_crc),
        .i_data (r_hold0),
        .o_crc  (crc_fed)
    );

    always_comb begin
        n_start_ok   = r_start_ok;
        n_version_ok = r_version_ok;
        n_type       = r_type;
        n_seq        = r_seq;
        n_length     = r_length;
        n_crc        = r_crc;

        if (r_byte_count == OFS_START_ONE && i_data_byte != r_start_one) begin
            n_start_ok = 1'b0;
        end
        if (r_byte_count == OFS_START_TWO && i_data_byte != r_start_two) begin
            n_start_ok = 1'b0;
        end
        if (r_byte_count == OFS_VERSION && i_data_byte != r_version) begin
            n_version_ok = 1'b0;
        end
        if (r_byte_count == OFS_TYPE) begin
            n_type = i_data_byte;
        end
        if (r_byte_count == OFS_SEQ) begin
            n_seq = i_data_byte;
        end
        if (r_byte_count == OFS_LENGTH) begin
            n_length = i_data_byte;
        end
        if (r_byte_count >= OFS_SEQ) begin
            n_crc = crc_fed;
        end

        // Saturate so an over-long frame cannot wrap into a plausible length
        n_byte_count = (r_byte_count == COUNT_MAX) ? COUNT_MAX : r_byte_count + 8'd1;

        store_ofs = r_byte_count - OFS_PAYLOAD;
        store_we  = in_accept && (r_byte_count >= OFS_PAYLOAD) && (store_ofs < MAX_LEN);

        // Checks in priority order; received CRC is low byte first
        if (n_byte_count < MIN_FRAME_LEN) begin
            n_status = ST_SHORT;
        end else if (!n_start_ok) begin
            n_status = ST_BAD_START;
        end else if (!n_version_ok) begin
            n_status = ST_BAD_VERSION;
        end else if (n_length > MAX_LEN
                     || {1'b0, n_byte_count} != ({1'b0, n_length} + FRAME_OVERHEAD)) begin
            n_status = ST_BAD_LENGTH;
        end else if (n_crc != {i_data_byte, r_hold1}) begin
            n_status = ST_BAD_CRC;
        end else begin
            n_status = ST_OK;
        end
        frame_ok = (n_status == ST_OK);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= 8'd0;
            r_crc        <= CRC_INIT;
            r_start_ok   <= 1'b1;
            r_version_ok <= 1'b1;
            r_length     <= 8'd0;
            r_type       <= 8'd0;
            r_seq        <= 8'd0;
            r_hold0      <= 8'd0;
            r_hold1      <= 8'd0;
        end else if (in_accept) begin
            if (i_last_byte) begin
                // Return the frame state to its idle values for the next frame
                r_byte_count <= 8'd0;
                r_crc        <= CRC_INIT;
                r_start_ok   <= 1'b1;
                r_version_ok <= 1'b1;
                r_length     <= 8'd0;
                r_type       <= 8'd0;
                r_seq        <= 8'd0;
                r_hold0      <= 8'd0;
                r_hold1      <= 8'd0;
            end else begin
                r_byte_count <= n_byte_count;
                r_crc        <= n_crc;
                r_start_ok   <= n_start_ok;
                r_version_ok <= n_version_ok;
                r_length     <= n_length;
                r_type       <= n_type;
                r_seq        <= n_seq;
                r_hold0      <= r_hold1;
                r_hold1      <= i_data_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[store_ofs[IDX_W-1:0]] <= i_data_byte;
        end
    end

    // ------------------------------------------------------------------
    // Result register and payload burst
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_burst     <= 1'b0;
            r_rd_idx    <= '0;
            r_left      <= '0;
        end else begin
            if (out_free) begin
                r_out_valid <= load_hdr || load_burst;
            end
            if (load_hdr) begin
                r_burst  <= frame_ok && (n_length != 8'd0);
                r_rd_idx <= '0;
                r_left   <= n_length[LEFT_W-1:0];
            end else if (load_burst) begin
                r_burst  <= (r_left != LEFT_W'(1));
                r_rd_idx <= r_rd_idx + IDX_W'(1);
                r_left   <= r_left - LEFT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_hdr) begin
            r_status     <= n_status;
            r_out_type   <= frame_ok ? n_type : 8'd0;
            r_out_seq    <= frame_ok ? n_seq : 8'd0;
            r_out_len    <= frame_ok ? n_length[5:0] : 6'd0;
            r_out_byte   <= 8'd0;
            r_out_bvalid <= 1'b0;
            r_out_last   <= !frame_ok || (n_length == 8'd0);
        end else if (load_burst) begin
            // Header fields hold from the header result; advance through the store
            r_status     <= ST_OK;
            r_out_byte   <= r_store[r_rd_idx];
            r_out_bvalid <= 1'b1;
            r_out_last   <= (r_left == LEFT_W'(1));
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_msg_type     = r_out_type;
    assign o_seq_num      = r_out_seq;
    assign o_pay_len      = r_out_len;
    assign o_payload_byte = r_out_byte;
    assign o_byte_valid   = r_out_bvalid;
    assign o_last_result  = r_out_last;

endmodule

// ===== sv/cfpd_crc_byte.sv =====
module cfpd_crc_byte
    import cfpd_pkg::*;
(
    input  logic [15:0] i_crc,
    input  logic [7:0]  i_data,
    output logic [15:0] o_crc
);

    logic [15:0] crc_work;

    // One byte of CRC-16, MSB first, unrolled over eight bit steps
    always_comb begin
        crc_work = i_crc ^ {i_data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (crc_work[15]) begin
                crc_work = {crc_work[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc_work = {crc_work[14:0], 1'b0};
            end
        end
        o_crc = crc_work;
    end

endmodule

// ===== tb/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import cfpd_pkg::*;

    localparam int PAY_MAX      = 32;
    localparam int PHASE_BYTES  = 16;   // minimum random frame bytes per idling phase
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 100000;

    // One result as the block presents it
    typedef struct packed {
        t_status    status;
        logic [7:0] msg_type;
        logic [7:0] seq_num;
        logic [5:0] pay_len;
        logic [7:0] payload_byte;
        logic       byte_valid;
        logic       last_result;
    } t_frame_result;

    typedef enum int {
        FR_GOOD, FR_SHORT, FR_BAD_START, FR_BAD_VERSION,
        FR_BAD_LENGTH, FR_BAD_CRC, FR_NOISE
    } t_frame_kind;

    // span is the payload length, or the raw byte count for short and noise frames
    typedef struct {
        t_frame_kind kind;
        int          span;
        bit          typed;
        t_status     status;
    } t_directed_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_data_byte;
    logic        i_last_byte;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [2:0]  o_status;
    logic [7:0]  o_msg_type;
    logic [7:0]  o_seq_num;
    logic [5:0]  o_pay_len;
    logic [7:0]  o_payload_byte;
    logic        o_byte_valid;
    logic        o_last_result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Shadow of the configuration registers
    logic [7:0] cfg_start_one;
    logic [7:0] cfg_start_two;
    logic [7:0] cfg_version;

    // Decoder state as the predictor tracks it
    logic [7:0]  rx_count;
    logic [15:0] rx_crc;
    bit          rx_start_ok;
    bit          rx_version_ok;
    logic [7:0]  rx_len;
    logic [7:0]  rx_type;
    logic [7:0]  rx_seq;
    logic [7:0]  rx_held [2];
    logic [7:0]  rx_payload [PAY_MAX];

    t_frame_result pending_results [$];
    logic [7:0]    frame_bytes [$];

    int idle_pct;
    int stall_pct;
    int error_count;
    int cycle_count = 0;
    int results_added;

    // Directed frames: minimal short frame, empty good frame, bad start, bad CRC
    t_directed_row directed_rows [4] = '{
        '{FR_SHORT,     1, 1'b1, ST_SHORT},
        '{FR_GOOD,      0, 1'b0, ST_OK},
        '{FR_BAD_START, 0, 1'b1, ST_BAD_START},
        '{FR_BAD_CRC,   0, 1'b1, ST_BAD_CRC}
    };

    crc_framed_packet_decoder_core #(
        .MAX_PAYLOAD(PAY_MAX)
    ) u_top (.*);

    always #10 i_clk = ~i_clk;

    // Give up on a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Receiver back-pressure, redrawn every cycle
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // CRC-16/CCITT-FALSE, one byte MSB first
    function automatic logic [15:0] crc16_ccitt(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    task automatic clear_frame_state();
        rx_count      = '0;
        rx_crc        = CRC_INIT;
        rx_start_ok   = 1'b1;
        rx_version_ok = 1'b1;
        rx_len        = '0;
        rx_type       = '0;
        rx_seq        = '0;
        rx_held[0]    = '0;
        rx_held[1]    = '0;
    endtask

    // Advance the predictor by one accepted byte; on the final byte queue the results
    task automatic decode_byte(input logic [7:0] b, input logic is_last);
        int            idx;
        int            n;
        t_status       st;
        t_frame_result r;
        idx = rx_count;
        if (idx == OFS_START_ONE && b != cfg_start_one) rx_start_ok = 1'b0;
        if (idx == OFS_START_TWO && b != cfg_start_two) rx_start_ok = 1'b0;
        if (idx == OFS_VERSION && b != cfg_version) rx_version_ok = 1'b0;
        if (idx == OFS_TYPE) rx_type = b;
        if (idx == OFS_SEQ) rx_seq = b;
        if (idx == OFS_LENGTH) rx_len = b;
        if (idx >= OFS_PAYLOAD && idx - OFS_PAYLOAD < PAY_MAX) rx_payload[idx - OFS_PAYLOAD] = b;
        // CRC trails by two bytes so the last two held back are the received CRC
        if (idx >= OFS_SEQ) rx_crc = crc16_ccitt(rx_crc, rx_held[0]);
        rx_held[0] = rx_held[1];
        rx_held[1] = b;
        if (rx_count != COUNT_MAX) rx_count = rx_count + 8'd1;
        results_added = 0;
        if (!is_last) return;

        if (rx_count < MIN_FRAME_LEN) st = ST_SHORT;
        else if (!rx_start_ok) st = ST_BAD_START;
        else if (!rx_version_ok) st = ST_BAD_VERSION;
        else if (rx_len > PAY_MAX || int'(rx_count) != 8 + int'(rx_len)) st = ST_BAD_LENGTH;
        else if (rx_crc != {rx_held[1], rx_held[0]}) st = ST_BAD_CRC;
        else st = ST_OK;

        n = (st == ST_OK) ? int'(rx_len) : 0;
        r = '0;
        r.status      = st;
        r.msg_type    = (st == ST_OK) ? rx_type : 8'd0;
        r.seq_num     = (st == ST_OK) ? rx_seq : 8'd0;
        r.pay_len     = (st == ST_OK) ? rx_len[5:0] : 6'd0;
        r.last_result = (n == 0);
        pending_results.push_back(r);
        for (int k = 0; k < n; k++) begin
            r.payload_byte = rx_payload[k];
            r.byte_valid   = 1'b1;
            r.last_result  = (k + 1 == n);
            pending_results.push_back(r);
        end
        results_added = n + 1;
        clear_frame_state();
    endtask

    // Build the bytes of one frame against the current register settings
    task automatic build_frame(input t_frame_kind kind, input int span);
        logic [7:0]  s1;
        logic [7:0]  s2;
        logic [7:0]  ver;
        logic [7:0]  len;
        logic [7:0]  b;
        logic [15:0] crc;
        int          pay_n;
        frame_bytes.delete();
        if (kind == FR_SHORT || kind == FR_NOISE) begin
            repeat (span) frame_bytes.push_back(8'($urandom));
            return;
        end
        s1    = cfg_start_one;
        s2    = cfg_start_two;
        ver   = cfg_version;
        len   = 8'(span);
        pay_n = span;
        case (kind)
            FR_BAD_START: begin
                if ($urandom_range(1)) s1 ^= 8'($urandom_range(255, 1));
                else s2 ^= 8'($urandom_range(255, 1));
            end
            FR_BAD_VERSION: ver ^= 8'($urandom_range(255, 1));
            FR_BAD_LENGTH: begin
                case ($urandom_range(2))
                    // length over the maximum but consistent: spills past the store
                    0: begin
                        len   = 8'($urandom_range(63, PAY_MAX + 1));
                        pay_n = len;
                    end
                    1: begin
                        len   = 8'($urandom_range(255, 64));
                        pay_n = $urandom_range(8);
                    end
                    // legal length, wrong byte count
                    default: begin
                        pay_n = (span == 0 || $urandom_range(1)) ?
                                span + $urandom_range(3, 1) : span - 1;
                    end
                endcase
            end
            default: ;
        endcase
        frame_bytes.push_back(s1);
        frame_bytes.push_back(s2);
        frame_bytes.push_back(ver);
        frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(len);
        crc = CRC_INIT;
        for (int i = OFS_VERSION; i < OFS_PAYLOAD; i++) crc = crc16_ccitt(crc, frame_bytes[i]);
        repeat (pay_n) begin
            b = 8'($urandom);
            frame_bytes.push_back(b);
            crc = crc16_ccitt(crc, b);
        end
        if (kind == FR_BAD_CRC) crc ^= 16'($urandom_range(65535, 1));
        frame_bytes.push_back(crc[7:0]);
        frame_bytes.push_back(crc[15:8]);
    endtask

    // Present one request at the falling edge and hold it until accepted
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= is_last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        decode_byte(b, is_last);
        @(negedge i_clk);
    endtask

    task automatic send_frame(input t_frame_kind kind, input int span);
        build_frame(kind, span);
        foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    endtask

    // Half well-formed frames with random content, the rest broken or noise
    task automatic send_random_frame();
        int          pick;
        int          span;
        t_frame_kind kind;
        pick = $urandom_range(99);
        if (pick < 50) kind = FR_GOOD;
        else if (pick < 60) kind = FR_BAD_START;
        else if (pick < 68) kind = FR_BAD_VERSION;
        else if (pick < 78) kind = FR_BAD_LENGTH;
        else if (pick < 88) kind = FR_BAD_CRC;
        else if (pick < 93) kind = FR_SHORT;
        else kind = FR_NOISE;
        pick = $urandom_range(99);
        if (kind == FR_SHORT) span = $urandom_range(7, 1);
        else if (kind == FR_NOISE) span = $urandom_range(20, 1);
        else if (pick < 70) span = $urandom_range(6);
        else if (pick < 85) span = PAY_MAX;
        else span = $urandom_range(PAY_MAX);
        send_frame(kind, span);
    endtask

    // Register write: setup cycle, then access cycle until pready
    task automatic write_reg(input t_reg_index idx, input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'($urandom), value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_START_ONE: cfg_start_one = value;
            REG_START_TWO: cfg_start_two = value;
            REG_VERSION:   cfg_version   = value;
            default: ;     // unmapped: the block drops it
        endcase
    endtask

    // Drop valid and hold off until every expected result has left the block
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic report_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endtask

    task automatic check_result(input t_frame_result want);
        report_field("status", 8'(want.status), 8'(o_status));
        report_field("msg_type", want.msg_type, o_msg_type);
        report_field("seq_num", want.seq_num, o_seq_num);
        report_field("pay_len", 8'(want.pay_len), 8'(o_pay_len));
        report_field("payload_byte", want.payload_byte, o_payload_byte);
        report_field("byte_valid", 8'(want.byte_valid), 8'(o_byte_valid));
        report_field("last_result", 8'(want.last_result), 8'(o_last_result));
    endtask

    // Compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: status %0d, byte_valid %0b", o_status, o_byte_valid);
                error_count++;
            end else begin
                check_result(pending_results.pop_front());
            end
        end
    end

    initial begin
        t_frame_result hdr;
        int            phase_bytes;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_data_byte   = '0;
        i_last_byte   = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        idle_pct      = 0;
        stall_pct     = 0;
        error_count   = 0;
        results_added = 0;
        cfg_start_one = START_ONE_RST;
        cfg_start_two = START_TWO_RST;
        cfg_version   = VERSION_RST;
        clear_frame_state();

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed frames at reset settings; error rows carry their status by hand
        foreach (directed_rows[i]) begin
            send_frame(directed_rows[i].kind, directed_rows[i].span);
            if (directed_rows[i].typed) begin
                repeat (results_added) void'(pending_results.pop_back());
                hdr             = '0;
                hdr.status      = directed_rows[i].status;
                hdr.last_result = 1'b1;
                pending_results.push_back(hdr);
            end
        end

        // Random frames over four idling phases, register settings changed between them
        for (int ph = 0; ph < 4; ph++) begin
            wait_idle();
            case (ph)
                1: begin
                    write_reg(REG_START_ONE, 8'h00);
                    write_reg(REG_START_TWO, 8'hFF);
                    write_reg(REG_VERSION, 8'h00);
                    write_reg(REG_UNUSED, 8'($urandom));
                    idle_pct  = 56;
                    stall_pct = 0;
                end
                2: begin
                    write_reg(REG_START_ONE, 8'hFF);
                    write_reg(REG_START_TWO, 8'h00);
                    write_reg(REG_VERSION, 8'hFF);
                    idle_pct  = 0;
                    stall_pct = 56;
                end
                3: begin
                    write_reg(REG_START_ONE, 8'($urandom));
                    write_reg(REG_START_TWO, 8'($urandom));
                    write_reg(REG_VERSION, 8'($urandom));
                    write_reg(REG_UNUSED, 8'($urandom));
                    idle_pct  = 22;
                    stall_pct = 22;
                end
                default: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
            endcase
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES) begin
                send_random_frame();
                phase_bytes += frame_bytes.size();
            end
        end

        wait_idle();
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== crc_framed_packet_decoder_core.f =====
sv/cfpd_pkg.sv
sv/cfpd_crc_byte.sv
sv/crc_framed_packet_decoder_core.sv
tb/testbench.sv
